// File: design/lkr_pkg.sv
// ----------------------------------------------------------------------------
// lkr_pkg
// Shared types and codes for the LIFO stack with keyed removal.
// ----------------------------------------------------------------------------
package lkr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 64;
    localparam int COUNT_W   = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_COUNT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   popped_key;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

endpackage

// File: design/lkr_ram.sv
// ----------------------------------------------------------------------------
// lkr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lkr_engine.sv
// ----------------------------------------------------------------------------
// lkr_engine
// Sequencer around the entry store: push, pop, top-down key search with a
// shared 64-bit compare, and a one-entry-per-cycle gap closing pass.
// ----------------------------------------------------------------------------
module lkr_engine #(
    parameter int DEPTH = lkr_pkg::DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  lkr_pkg::t_in_item    i_req,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output lkr_pkg::t_out_item   o_res
);

    import lkr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POPRD = 5'b00010,
        S_SRCH  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_idx, n_idx;
    logic [KEY_W-1:0] r_key, n_key;
    logic [1:0]       r_status, n_status;
    logic [KEY_W-1:0] r_popped, n_popped;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [KEY_W-1:0] ram_rdata;
    logic             key_match;
    logic [CW-1:0]    fill_dec;
    logic [CW-1:0]    idx_ext;

    lkr_ram #(
        .WIDTH(KEY_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign key_match = (ram_rdata == r_key);
    assign fill_dec  = r_fill - CW'(1);
    assign idx_ext   = CW'(r_idx);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_key     = r_key;
        n_status  = r_status;
        n_popped  = r_popped;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = fill_dec[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_key    = i_req.key;
                    n_status = ST_OK;
                    n_popped = '0;
                    n_state  = S_DONE;
                    case (i_req.operation)
                        OP_PUSH: begin
                            if (r_fill == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_fill[AW-1:0];
                                ram_wdata = i_req.key;
                                n_fill    = r_fill + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_fill  = fill_dec;
                                n_state = S_POPRD;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_fill == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_idx   = fill_dec[AW-1:0];
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POPRD: begin
                n_popped = ram_rdata;
                n_state  = S_DONE;
            end
            S_SRCH: begin
                if (key_match) begin
                    ram_raddr = r_idx + AW'(1);
                    if (idx_ext + CW'(1) == r_fill) begin
                        n_fill  = fill_dec;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else begin
                    ram_raddr = r_idx - AW'(1);
                    if (r_idx == '0) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                ram_raddr = r_idx + AW'(2);
                if (idx_ext + CW'(2) == r_fill) begin
                    n_fill  = fill_dec;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_popped <= n_popped;
    end

    assign o_req_ready       = (r_state == S_IDLE);
    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.popped_key  = r_popped;
    assign o_res.entry_count = COUNT_W'(r_fill);

endmodule

// File: design/lifo_stack_with_keyed_removal.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_keyed_removal
// Bounded LIFO of 64-bit keys with push, pop, remove-by-key and count.
// ----------------------------------------------------------------------------
// One item is processed at a time; each gives one result through an output
// register. Push and count go straight to the done state; pop first reads the
// top entry from the store. Remove reads one entry per cycle from the top down
// through a single 64-bit comparator, then closes the gap moving one entry per
// cycle, both paced by the single store read port. Every item ends in a done
// state that hands its result off before the return to idle.
module lifo_stack_with_keyed_removal #(
    parameter int DEPTH = lkr_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lkr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lkr_pkg::t_out_item o_out_item
);

    import lkr_pkg::*;

    logic      r_out_valid;
    t_out_item r_out;
    logic      res_valid;
    logic      res_ready;
    t_out_item res;

    lkr_engine #(
        .DEPTH(DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_in_valid),
        .o_req_ready(o_in_ready),
        .i_req      (i_in_item),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LIFO stack with keyed removal. A shadow stack
// predicts status, popped key and count for every accepted item; results are
// checked in order while both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module tb;

    import lkr_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int N_RANDOM    = 1225;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    class stack_shadow;
        logic [KEY_W-1:0] slots [STACK_DEPTH];
        int               fill;
        t_out_item        pending_results [$];
        int               errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [KEY_W-1:0] key_at(int idx);
            return slots[idx];
        endfunction

        function void note_op(t_in_item it);
            t_out_item r;
            int        hit;
            r.status     = ST_OK;
            r.popped_key = '0;
            hit          = -1;
            case (it.operation)
                OP_PUSH: begin
                    if (fill >= STACK_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        slots[fill] = it.key;
                        fill++;
                    end
                end
                OP_POP: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        fill--;
                        r.popped_key = slots[fill];
                    end
                end
                OP_REMOVE: begin
                    for (int i = fill - 1; i >= 0; i--)
                        if (hit < 0 && slots[i] == it.key) hit = i;
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        for (int j = hit; j + 1 < fill; j++) slots[j] = slots[j + 1];
                        fill--;
                    end
                end
                default: ;
            endcase
            r.entry_count = COUNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch("item with none expected", got.popped_key, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.popped_key !== want.popped_key)
                    report_mismatch("popped_key", got.popped_key, want.popped_key);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(got.entry_count),
                                    64'(want.entry_count));
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    bit               long_hold_req = 1'b0;
    bit               no_idle       = 1'b0;
    logic [KEY_W-1:0] key_pool [8];
    stack_shadow      shadow = new();

    lifo_stack_with_keyed_removal #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) shadow.note_op(i_in_item);
            if (o_out_valid && i_out_ready) shadow.check_result(o_out_item);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL lifo_stack_with_keyed_removal");
        $finish;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_in_item mk(t_op op, logic [KEY_W-1:0] key);
        t_in_item it;
        it.operation = op;
        it.key       = key;
        return it;
    endfunction

    function automatic logic [KEY_W-1:0] ascii_key();
        logic [KEY_W-1:0] k;
        int               len;
        k   = '0;
        len = $urandom_range(1, 8);
        for (int c = 0; c < len; c++) k[8*c +: 8] = 8'($urandom_range(33, 126));
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] push_key();
        case ($urandom_range(0, 3))
            0, 1:    return key_pool[$urandom_range(0, 7)];
            2:       return {$urandom, $urandom};
            default: return ascii_key();
        endcase
    endfunction

    function automatic t_in_item next_item(t_phase ph);
        int       r;
        int       push_w;
        int       pop_w;
        t_in_item it;
        r      = $urandom_range(0, 99);
        push_w = (ph == PH_FILL) ? 60 : (ph == PH_DRAIN) ? 20 : 35;
        pop_w  = push_w + ((ph == PH_FILL) ? 10 : 35);
        it.key = {$urandom, $urandom};
        if (r < push_w) begin
            it.operation = OP_PUSH;
            it.key       = push_key();
        end else if (r < pop_w) begin
            it.operation = OP_POP;
        end else if (r < 92) begin
            it.operation = OP_REMOVE;
            if (shadow.fill > 0 && $urandom_range(0, 3) != 0)
                it.key = shadow.key_at($urandom_range(0, shadow.fill - 1));
            else if ($urandom_range(0, 1) == 0)
                it.key = key_pool[$urandom_range(0, 7)];
        end else begin
            it.operation = OP_COUNT;
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        i_in_valid <= 1'b0;
        i_in_item  <= {2'($urandom), $urandom, $urandom};
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (shadow.pending() != 0);
    endtask

    initial begin
        t_phase ph;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        ph         = PH_MIX;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h0000_0000_0000_0001;
        key_pool[4] = 64'h4142_4344_4546_4748;
        for (int p = 5; p < 8; p++) key_pool[p] = ascii_key();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty stack corner cases
        send_item(mk(OP_COUNT, '1));
        send_item(mk(OP_POP, '0));
        send_item(mk(OP_REMOVE, '0));
        // fill to the brim with extreme keys at the bottom
        for (int p = 0; p < 5; p++) send_item(mk(OP_PUSH, key_pool[p]));
        for (int p = 5; p < STACK_DEPTH; p++) send_item(mk(OP_PUSH, ascii_key()));
        send_item(mk(OP_PUSH, key_pool[4]));
        send_item(mk(OP_REMOVE, key_pool[0]));
        send_item(mk(OP_REMOVE, 64'h5555_aaaa_5555_aaaa));
        send_item(mk(OP_REMOVE, key_pool[1]));
        send_item(mk(OP_POP, '1));
        send_item(mk(OP_COUNT, '0));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) ph = t_phase'($urandom_range(0, 2));
            if (n == N_RANDOM - 200) no_idle = 1'b1;
            if (n == 300) long_hold_req = 1'b1;
            if (n == 700) drain_results();
            if (!no_idle && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 16));
            send_item(next_item(ph));
        end

        drain_results();
        repeat (2 * STACK_DEPTH + 8) @(negedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("PASS lifo_stack_with_keyed_removal");
        else
            $display("FAIL lifo_stack_with_keyed_removal");
        $finish;
    end

endmodule
